@@ rtl/core/sync_framed_command_deframer_macros.svh @@
// Assertion macros shared by the deframer RTL.
// SFCD_ASSERT checks a same-cycle implication and SFCD_ASSERT_NXT checks
// a next-cycle implication. Both are sampled on clk and switched off
// while rst is high.
`ifndef SYNC_FRAMED_COMMAND_DEFRAMER_MACROS_SVH
`define SYNC_FRAMED_COMMAND_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SFCD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

`define SFCD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define SFCD_ASSERT(label, ante, cons)

`define SFCD_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ rtl/core/sfcd_pkg.sv @@
package sfcd_pkg;

  typedef enum logic [4:0] {
    PH_HUNT1 = 5'b00001,
    PH_HUNT2 = 5'b00010,
    PH_TYPE  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hFE;
  localparam logic [7:0] TYPE_MOVE   = 8'hFF;
  localparam logic [7:0] TYPE_SETPOS = 8'hFE;
  localparam logic [7:0] TYPE_ACCEL  = 8'hFD;

  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_SETPOS = 2'd1;
  localparam logic [1:0] KIND_ACCEL  = 2'd2;

  localparam int         STORE_DEPTH = 24;
  localparam int         IDX_W       = $clog2(STORE_DEPTH);
  localparam logic [4:0] LEN_MOVE    = 5'd16;
  localparam logic [4:0] LEN_SETPOS  = 5'd8;
  localparam logic [4:0] LEN_ACCEL   = 5'd24;

  // One byte handed to the parser.
  typedef struct packed {
    logic       step;
    logic [7:0] data;
  } step_t;

  // One decoded frame.
  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] x_target;
    logic [31:0] x_speed;
    logic [31:0] x_accel;
    logic [31:0] y_target;
    logic [31:0] y_speed;
    logic [31:0] y_accel;
  } frame_t;

  function automatic logic [4:0] frame_len(input logic [1:0] kind);
    logic [4:0] len;
    case (kind)
      KIND_MOVE:   len = LEN_MOVE;
      KIND_SETPOS: len = LEN_SETPOS;
      default:     len = LEN_ACCEL;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/sync_framed_command_deframer.sv @@
// Channel  Handshake               Payload
// -------  ----------------------  -------------------------------------------
// in       in_valid / in_ready     rx_byte
// out      out_valid / out_ready   frame_kind, frame_status, x_*, y_* words
//
// One byte is taken every cycle while in_ready is high. A checksum byte
// passes through the input register, and its result is then loaded into
// the result register, from which it is offered on the out channel. rst is
// synchronous and returns the parser to hunting for the first sync byte.
// in_ready falls only when a checksum byte sits in the input register while
// an earlier result is still waiting to be taken.
`include "sync_framed_command_deframer_macros.svh"

module sync_framed_command_deframer
  import sfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_kind,
  output logic        frame_status,
  output logic [31:0] x_target,
  output logic [31:0] x_speed,
  output logic [31:0] x_accel,
  output logic [31:0] y_target,
  output logic [31:0] y_speed,
  output logic [31:0] y_accel
);

  logic   vld_q;
  logic [7:0] byte_q;
  logic   stall;
  logic   at_check;
  step_t  st;
  frame_t frame, frame_q;

  // Only the checksum byte produces a result, so only it must wait for a
  // full result register to drain; every other byte passes straight on.
  assign stall    = vld_q && at_check && out_valid && !out_ready;
  assign in_ready = !stall;
  assign st       = '{step: vld_q && !stall, data: byte_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (in_ready) begin
      vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  sfcd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .at_check (at_check),
    .frame    (frame)
  );

  // Result register: a new frame may load in the same cycle as the old one
  // is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st.step && at_check) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st.step && at_check) begin
      frame_q <= frame;
    end
  end

  assign frame_kind   = frame_q.kind;
  assign frame_status = frame_q.status;
  assign x_target     = frame_q.x_target;
  assign x_speed      = frame_q.x_speed;
  assign x_accel      = frame_q.x_accel;
  assign y_target     = frame_q.y_target;
  assign y_speed      = frame_q.y_speed;
  assign y_accel      = frame_q.y_accel;

  `SFCD_ASSERT_NXT(a_check_held, stall, vld_q && at_check)
  `SFCD_ASSERT_NXT(a_result_loaded, st.step && at_check, out_valid)
  `SFCD_ASSERT(a_kind_legal, out_valid, frame_kind <= KIND_ACCEL)

endmodule

@@ rtl/core/sfcd_parser.sv @@
`include "sync_framed_command_deframer_macros.svh"

module sfcd_parser
  import sfcd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  step_t  st,
  output logic   at_check,
  output frame_t frame
);

  phase_t     phase, phase_next;
  logic [4:0] byte_count, count_next, count_inc;
  logic [7:0] sum_acc, sum_next;
  logic [1:0] kind, kind_next;
  logic       wr_en;
  logic [7:0] store [STORE_DEPTH];
  logic [31:0] word [STORE_DEPTH/4];

  assign count_inc = byte_count + 5'd1;
  assign at_check  = (phase == PH_CHECK);

  always_comb begin
    phase_next = phase;
    count_next = byte_count;
    sum_next   = sum_acc;
    kind_next  = kind;
    wr_en      = 1'b0;
    if (st.step) begin
      unique case (phase)
        PH_HUNT1: begin
          phase_next = (st.data == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end
        PH_HUNT2: begin
          // A broken pair swallows the byte; it is not retried as a start.
          phase_next = (st.data == SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
        end
        PH_TYPE: begin
          count_next = 5'd0;
          sum_next   = 8'd0;
          phase_next = PH_DATA;
          if (st.data == TYPE_MOVE) begin
            kind_next = KIND_MOVE;
          end else if (st.data == TYPE_SETPOS) begin
            kind_next = KIND_SETPOS;
          end else if (st.data == TYPE_ACCEL) begin
            kind_next = KIND_ACCEL;
          end else begin
            phase_next = PH_HUNT1;
          end
        end
        PH_DATA: begin
          wr_en      = (byte_count < 5'(STORE_DEPTH));
          sum_next   = sum_acc + st.data;
          count_next = count_inc;
          if (count_inc >= frame_len(kind)) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next = PH_HUNT1;
          count_next = 5'd0;
          sum_next   = 8'd0;
        end
        default: begin
          phase_next = (st.data == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT1;
      byte_count <= 5'd0;
      sum_acc    <= 8'd0;
      kind       <= KIND_MOVE;
    end else begin
      phase      <= phase_next;
      byte_count <= count_next;
      sum_acc    <= sum_next;
      kind       <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[byte_count[IDX_W-1:0]] <= st.data;
    end
  end

  for (genvar w = 0; w < STORE_DEPTH/4; w++) begin : g_word
    assign word[w] = {store[4*w+3], store[4*w+2], store[4*w+1], store[4*w]};
  end

  // Words are placed by frame type; unused fields read as zero.
  always_comb begin
    frame        = '0;
    frame.kind   = kind;
    frame.status = (st.data != sum_acc);
    frame.x_target = word[0];
    case (kind)
      KIND_MOVE: begin
        frame.x_speed  = word[1];
        frame.y_target = word[2];
        frame.y_speed  = word[3];
      end
      KIND_SETPOS: begin
        frame.y_target = word[1];
      end
      default: begin
        frame.x_speed  = word[1];
        frame.x_accel  = word[2];
        frame.y_target = word[3];
        frame.y_speed  = word[4];
        frame.y_accel  = word[5];
      end
    endcase
  end

  `SFCD_ASSERT(a_data_count, phase == PH_DATA, byte_count < frame_len(kind))
  `SFCD_ASSERT(a_hunt_clear, phase == PH_HUNT1, byte_count == 5'd0 && sum_acc == 8'd0)
  `SFCD_ASSERT_NXT(a_check_done, st.step && phase == PH_CHECK, phase == PH_HUNT1)

endmodule

@@ test/sync_framed_command_deframer_checker.sv @@
module sync_framed_command_deframer_checker
  import sfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  frame_kind,
  input  logic        frame_status,
  input  logic [31:0] x_target,
  input  logic [31:0] x_speed,
  input  logic [31:0] x_accel,
  input  logic [31:0] y_target,
  input  logic [31:0] y_speed,
  input  logic [31:0] y_accel,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  // Parser state, kept in step with the block on every accepted byte.
  phase_t      parse_phase;
  logic [4:0]  got_bytes;
  logic [4:0]  need_bytes;
  logic [7:0]  running_sum;
  logic [1:0]  cur_kind;
  logic [7:0]  frame_bytes [STORE_DEPTH];
  frame_t      decoded_frames [$];
  int unsigned error_tally = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("deframer mismatch at %0t: %s expected %h, got %h", $time, what, want, got);
    error_tally++;
  endtask

  function automatic logic [31:0] payload_word(input int unsigned w);
    return {frame_bytes[4*w+3], frame_bytes[4*w+2], frame_bytes[4*w+1], frame_bytes[4*w]};
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    frame_t f;
    case (parse_phase)
      PH_HUNT2: begin
        parse_phase = (b == SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
      end
      PH_TYPE: begin
        got_bytes   = '0;
        running_sum = '0;
        parse_phase = PH_DATA;
        case (b)
          TYPE_MOVE: begin
            cur_kind   = KIND_MOVE;
            need_bytes = LEN_MOVE;
          end
          TYPE_SETPOS: begin
            cur_kind   = KIND_SETPOS;
            need_bytes = LEN_SETPOS;
          end
          TYPE_ACCEL: begin
            cur_kind   = KIND_ACCEL;
            need_bytes = LEN_ACCEL;
          end
          default: begin
            parse_phase = PH_HUNT1;
          end
        endcase
      end
      PH_DATA: begin
        frame_bytes[got_bytes] = b;
        running_sum = running_sum + b;
        got_bytes   = got_bytes + 5'd1;
        if (got_bytes == need_bytes) begin
          parse_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        f        = '0;
        f.kind   = cur_kind;
        f.status = (b != running_sum);
        f.x_target = payload_word(0);
        case (cur_kind)
          KIND_SETPOS: begin
            f.y_target = payload_word(1);
          end
          KIND_MOVE: begin
            f.x_speed  = payload_word(1);
            f.y_target = payload_word(2);
            f.y_speed  = payload_word(3);
          end
          default: begin
            f.x_speed  = payload_word(1);
            f.x_accel  = payload_word(2);
            f.y_target = payload_word(3);
            f.y_speed  = payload_word(4);
            f.y_accel  = payload_word(5);
          end
        endcase
        decoded_frames.push_back(f);
        parse_phase = PH_HUNT1;
        got_bytes   = '0;
        running_sum = '0;
      end
      default: begin
        parse_phase = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  endtask

  task automatic check_frame();
    frame_t want;
    if (decoded_frames.size() == 0) begin
      report_mismatch("result with none outstanding, frame_kind", '0, frame_kind);
    end else begin
      want = decoded_frames.pop_front();
      if (frame_kind != want.kind) report_mismatch("frame_kind", want.kind, frame_kind);
      if (frame_status != want.status)
        report_mismatch("frame_status", want.status, frame_status);
      if (x_target != want.x_target) report_mismatch("x_target", want.x_target, x_target);
      if (x_speed != want.x_speed) report_mismatch("x_speed", want.x_speed, x_speed);
      if (x_accel != want.x_accel) report_mismatch("x_accel", want.x_accel, x_accel);
      if (y_target != want.y_target) report_mismatch("y_target", want.y_target, y_target);
      if (y_speed != want.y_speed) report_mismatch("y_speed", want.y_speed, y_speed);
      if (y_accel != want.y_accel) report_mismatch("y_accel", want.y_accel, y_accel);
    end
  endtask

  // A result leaves only after its checksum byte has passed the input and
  // result registers, so the result is checked before the byte of the same edge is absorbed.
  always @(posedge clk) begin
    if (rst) begin
      parse_phase = PH_HUNT1;
      got_bytes   = '0;
      need_bytes  = LEN_MOVE;
      running_sum = '0;
      cur_kind    = KIND_MOVE;
      decoded_frames.delete();
    end else begin
      if (out_valid && out_ready) check_frame();
      if (in_valid && in_ready) absorb_byte(rx_byte);
    end
    fail_count    <= error_tally;
    pending_count <= decoded_frames.size();
  end

endmodule

@@ test/tb_sync_framed_command_deframer.sv @@
module tb_sync_framed_command_deframer;
  import sfcd_pkg::*;

  // Roughly this many bytes are offered in total. The final stretch is run
  // without any idling on either side.
  localparam int unsigned BYTE_TARGET   = 2000;
  localparam int unsigned CALM_TAIL     = 300;
  // This bound is generous beside the longest idle bursts of the byte source and
  // the result sink, while still catching a hung block quickly.
  localparam int unsigned QUIET_LIMIT   = 2000;
  // This is ample time for the block to settle.
  localparam int unsigned SETTLE_CYCLES = 20;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_kind;
  logic        frame_status;
  logic [31:0] x_target;
  logic [31:0] x_speed;
  logic [31:0] x_accel;
  logic [31:0] y_target;
  logic [31:0] y_speed;
  logic [31:0] y_accel;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;
  // When clear, neither the byte source nor the result sink starts a new idle burst.
  bit          allow_gaps = 1'b0;

  sync_framed_command_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_kind   (frame_kind),
    .frame_status (frame_status),
    .x_target     (x_target),
    .x_speed      (x_speed),
    .x_accel      (x_accel),
    .y_target     (y_target),
    .y_speed      (y_speed),
    .y_accel      (y_accel)
  );

  sync_framed_command_deframer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_kind    (frame_kind),
    .frame_status  (frame_status),
    .x_target      (x_target),
    .x_speed       (x_speed),
    .x_accel       (x_accel),
    .y_target      (y_target),
    .y_speed       (y_speed),
    .y_accel       (y_accel),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The result sink. It stalls in random bursts while idling is allowed,
  // and otherwise takes every result at once. It changes only on the falling
  // edge, so the block sees a settled value at the rising edge.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (allow_gaps && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // The watchdog ends the run if no item moves on either channel for too
  // long, which covers a hung block as well as results that never arrive.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("sync_framed_command_deframer regression: fail");
    $finish;
  end

  // Byte values lean towards the codes that matter to the parser, so that
  // sync, type and all-ones or all-zeros payloads turn up often.
  function automatic logic [7:0] pick_byte();
    logic [7:0] value;
    case ($urandom_range(0, 15))
      0, 1:    value = 8'h00;
      2, 3:    value = 8'hFF;
      4:       value = 8'hFE;
      5:       value = 8'hFD;
      default: value = 8'($urandom_range(0, 255));
    endcase
    return value;
  endfunction

  // Offers one byte and holds it until the block accepts it. It is entered
  // and left on a falling edge. An idle burst may precede the byte; valid is
  // then lowered and raised again on different falling edges, never both in
  // one step.
  task automatic push_byte(input logic [7:0] value);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends a whole frame: the sync pair, the type byte, the payload and the
  // checksum. A negative fill gives random payload bytes, otherwise every
  // payload byte takes the fill value. A spoilt checksum has one bit flipped.
  task automatic send_frame(input logic [7:0] type_code, input int unsigned len,
                            input int fill, input bit spoil_sum);
    logic [7:0] sum;
    logic [7:0] value;
    sum = 8'h00;
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(type_code);
    repeat (len) begin
      value = (fill < 0) ? pick_byte() : fill[7:0];
      sum   = sum + value;
      push_byte(value);
    end
    if (spoil_sum) begin
      sum = sum ^ (8'h01 << $urandom_range(0, 7));
    end
    push_byte(sum);
  endtask

  // A frame of random kind. Most carry a correct checksum, and now and then
  // the whole payload is held at zero or at all ones.
  task automatic send_random_frame();
    logic [7:0]  type_code;
    int unsigned len;
    int          fill;
    case ($urandom_range(0, 2))
      0: begin
        type_code = TYPE_MOVE;
        len       = LEN_MOVE;
      end
      1: begin
        type_code = TYPE_SETPOS;
        len       = LEN_SETPOS;
      end
      default: begin
        type_code = TYPE_ACCEL;
        len       = LEN_ACCEL;
      end
    endcase
    case ($urandom_range(0, 9))
      0:       fill = 8'h00;
      1:       fill = 8'hFF;
      default: fill = -1;
    endcase
    send_frame(type_code, len, fill, $urandom_range(0, 3) == 0);
  endtask

  // Broken sequences: a sync pair cut short, an unknown type byte, or a frame
  // abandoned part-way, whose remainder is then filled by whatever follows.
  task automatic send_broken_sequence();
    logic [7:0] value;
    case ($urandom_range(0, 2))
      0: begin
        value = 8'($urandom_range(0, 255));
        if (value == SYNC_SECOND) value = SYNC_FIRST;
        push_byte(SYNC_FIRST);
        push_byte(value);
      end
      1: begin
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'($urandom_range(0, 8'hFC)));
      end
      default: begin
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte($urandom_range(0, 1) ? TYPE_MOVE : TYPE_ACCEL);
        repeat ($urandom_range(1, 12)) push_byte(pick_byte());
      end
    endcase
  endtask

  initial begin
    int unsigned next_switch;

    // Reset is held from time zero and released on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening with idling allowed. A sync pair broken by a plain
    // byte, then one broken by a second 0xFF (which must not count as a new
    // first sync byte, so the 0xFE after it is ignored too), then an unknown
    // type byte, and a set-position frame with an all-ones payload.
    allow_gaps = 1'b1;
    push_byte(SYNC_FIRST);
    push_byte(8'h00);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(8'h00);
    send_frame(TYPE_SETPOS, LEN_SETPOS, 8'hFF, 1'b0);

    // Random part. Mostly well-formed frames, with noise and broken
    // sequences mixed in. Idling is switched on and off in stretches, and
    // the tail of the run has none at all.
    next_switch = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent + CALM_TAIL >= BYTE_TARGET) begin
        allow_gaps = 1'b0;
      end else if (bytes_sent >= next_switch) begin
        allow_gaps  = ($urandom_range(0, 3) != 0);
        next_switch = bytes_sent + 200;
      end
      case ($urandom_range(0, 19))
        14, 15, 16: begin
          repeat ($urandom_range(1, 6)) push_byte(pick_byte());
        end
        17, 18, 19: begin
          send_broken_sequence();
        end
        default: begin
          send_random_frame();
        end
      endcase
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then give the block time to show
    // any result that it should not produce.
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("sync_framed_command_deframer regression: pass");
    end else begin
      $display("sync_framed_command_deframer regression: fail");
    end
    $finish;
  end

endmodule
